// ===== sv/avcc2ab_pkg.sv =====
// Shared types and constants of the length-prefixed to start-code NAL converter.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package avcc2ab_pkg;

	// Default depth of the parameter-set prefix memory, in bytes.
	localparam int PREFIX_DEPTH_DEF = 56;

	// Status codes carried with a result word.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TRUNC     = 2'd1;
	localparam logic [1:0] ST_NEG_LEN   = 2'd2;
	localparam logic [1:0] ST_BAD_EXTRA = 2'd3;

	// NAL unit type of an IDR slice.
	localparam logic [4:0] NAL_TYPE_IDR = 5'd5;

	// What the output word carries in the current cycle.
	typedef enum logic [2:0] {
		EM_PREFIX,
		EM_ZERO,
		EM_ONE,
		EM_DATA,
		EM_STAT
	} emit_sel_t;

	// Work an accepted input word calls for.
	typedef struct packed {
		logic wr;   // write a four-byte start code into the prefix memory
		logic rep;  // replay the stored prefix, then one extra zero byte
		logic sc;   // emit a three-byte start code
		logic dat;  // emit the input byte itself
		logic st;   // emit one status-only word
	} plan_t;

	// Datapath to controller.
	typedef struct packed {
		plan_t plan_in;   // plan of the word on the input side
		logic  dat_q;     // held plan of the word in work
		logic  st_q;
		logic  rep_last;  // replay pointer sits on the last prefix byte
		logic  out_free;  // output register can take a word this cycle
	} dp_status_t;

	// Controller to datapath.
	typedef struct packed {
		logic      accept;
		logic      emit;
		emit_sel_t sel;
		logic      last_res;
		logic      wr_sc;
		logic [1:0] wr_k;
	} ctl_cmd_t;

endpackage

// ===== sv/avcc2ab_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module avcc2ab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 56
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/avcc2ab_ctrl.sv =====
// Sequencing controller of the NAL converter: steps through the words that one
// accepted input word produces. Depends on avcc2ab_pkg.
`timescale 1ns / 1ps

module avcc2ab_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_valid,
	output logic                   s_ready,
	input  avcc2ab_pkg::dp_status_t stat,
	output avcc2ab_pkg::ctl_cmd_t   cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_WR0,
		S_WR1,
		S_WR2,
		S_WR3,
		S_REP,
		S_Z4,
		S_SC0,
		S_SC1,
		S_SC2,
		S_DAT,
		S_STAT
	} state_t;

	state_t state_q;
	state_t first_st;
	state_t next_st;
	logic   emitting;
	logic   final_word;
	logic   accept;

	// Entry state for the word on the input side.
	always_comb begin
		if (stat.plan_in.wr) begin
			first_st = S_WR0;
		end else if (stat.plan_in.rep) begin
			first_st = S_REP;
		end else if (stat.plan_in.sc) begin
			first_st = S_SC0;
		end else if (stat.plan_in.dat) begin
			first_st = S_DAT;
		end else if (stat.plan_in.st) begin
			first_st = S_STAT;
		end else begin
			first_st = S_IDLE;
		end
	end

	always_comb begin
		emitting = (state_q == S_REP) || (state_q == S_Z4) || (state_q == S_SC0) ||
			(state_q == S_SC1) || (state_q == S_SC2) || (state_q == S_DAT) ||
			(state_q == S_STAT);
		final_word = ((state_q == S_SC2) && !stat.dat_q) || (state_q == S_DAT) ||
			(state_q == S_STAT);
		s_ready = (state_q == S_IDLE) || (final_word && stat.out_free);
		accept = s_valid && s_ready;

		cmd.accept   = accept;
		cmd.emit     = emitting && stat.out_free;
		cmd.last_res = final_word;
		cmd.wr_sc    = 1'b0;
		cmd.wr_k     = 2'd0;
		case (state_q)
			S_WR0: begin cmd.wr_sc = 1'b1; cmd.wr_k = 2'd0; end
			S_WR1: begin cmd.wr_sc = 1'b1; cmd.wr_k = 2'd1; end
			S_WR2: begin cmd.wr_sc = 1'b1; cmd.wr_k = 2'd2; end
			S_WR3: begin cmd.wr_sc = 1'b1; cmd.wr_k = 2'd3; end
			default: ;
		endcase
		case (state_q)
			S_REP:  cmd.sel = avcc2ab_pkg::EM_PREFIX;
			S_SC2:  cmd.sel = avcc2ab_pkg::EM_ONE;
			S_DAT:  cmd.sel = avcc2ab_pkg::EM_DATA;
			S_STAT: cmd.sel = avcc2ab_pkg::EM_STAT;
			default: cmd.sel = avcc2ab_pkg::EM_ZERO;
		endcase
	end

	always_comb begin
		next_st = state_q;
		if (accept) begin
			next_st = first_st;
		end else begin
			case (state_q)
				S_WR0: next_st = S_WR1;
				S_WR1: next_st = S_WR2;
				S_WR2: next_st = S_WR3;
				S_WR3: next_st = stat.st_q ? S_STAT : S_IDLE;
				S_REP: if (stat.out_free && stat.rep_last) next_st = S_Z4;
				S_Z4:  if (stat.out_free) next_st = S_SC0;
				S_SC0: if (stat.out_free) next_st = S_SC1;
				S_SC1: if (stat.out_free) next_st = S_SC2;
				S_SC2: if (stat.out_free) next_st = stat.dat_q ? S_DAT : S_IDLE;
				S_DAT: if (stat.out_free) next_st = S_IDLE;
				S_STAT: if (stat.out_free) next_st = S_IDLE;
				default: next_st = S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= next_st;
		end
	end

endmodule

// ===== sv/avcc2ab_dp.sv =====
// Datapath of the NAL converter: extradata and packet parsers, prefix memory,
// held word plan and output register. Depends on avcc2ab_pkg and avcc2ab_ram.
`timescale 1ns / 1ps

module avcc2ab_dp #(
	parameter int PREFIX_DEPTH = avcc2ab_pkg::PREFIX_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [7:0]              s_data,
	input  logic                    s_op,
	input  logic                    s_last,
	input  avcc2ab_pkg::ctl_cmd_t   cmd,
	output avcc2ab_pkg::dp_status_t stat,
	output logic                    m_valid,
	input  logic                    m_ready,
	output logic [7:0]              m_data,
	output logic [3:0]              m_user,
	output logic                    m_last
);

	localparam int AW = $clog2(PREFIX_DEPTH);
	localparam int LW = $clog2(PREFIX_DEPTH + 1);
	localparam logic [2:0] HDR_LAST = 3'd5;

	typedef enum logic [2:0] {
		E_HEADER,
		E_SIZE_HI,
		E_SIZE_LO,
		E_PAYLOAD,
		E_PPS_COUNT,
		E_DONE
	} ex_phase_t;

	typedef enum logic [1:0] {
		P_LEN,
		P_HEAD,
		P_BODY,
		P_SKIP
	} pk_phase_t;

	// Parser state.
	ex_phase_t   eph_q, eph_n;
	logic [2:0]  hb_q, hb_n;
	logic [7:0]  ul_q, ul_n;
	logic [15:0] ub_q, ub_n;
	logic        pps_q, pps_n;
	logic        bad_q, bad_n;
	logic [LW-1:0] plen_q, plen_n;
	pk_phase_t   pph_q, pph_n;
	logic [1:0]  lb_q, lb_n;
	logic [23:0] nl_q, nl_n;
	logic [30:0] nbl_q, nbl_n;

	// Held plan of the word in work.
	logic          dat_q, st_q, eop_q;
	logic [1:0]    fstat_q, fstat_n;
	logic [7:0]    byte_q;
	logic [AW-1:0] wbase_q, wbase_n;
	logic [AW-1:0] idx_q;

	// Output register.
	logic       ovld_q;
	logic [7:0] obyte_q;
	logic       obv_q, olast_q, oeop_q;
	logic [1:0] ostat_q;

	avcc2ab_pkg::plan_t plan;
	logic          adv;
	logic          pay_we;
	logic [31:0]   nlv;
	logic [16:0]   fit_sum;
	logic          rep_last;
	logic          out_free;
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_wdata, ram_rdata;
	logic [7:0]    emit_byte;

	assign nlv      = {nl_q, s_data};
	assign fit_sum  = 17'(plen_q) + 17'd4 + {1'b0, ub_q[15:8], s_data};
	assign rep_last = (LW'(idx_q) + LW'(1)) == plen_q;
	assign out_free = !ovld_q || m_ready;

	always_comb begin
		eph_n = eph_q; hb_n = hb_q; ul_n = ul_q; ub_n = ub_q;
		pps_n = pps_q; bad_n = bad_q; plen_n = plen_q;
		pph_n = pph_q; lb_n = lb_q; nl_n = nl_q; nbl_n = nbl_q;
		plan = '0;
		fstat_n = avcc2ab_pkg::ST_OK;
		wbase_n = wbase_q;
		adv = 1'b0;
		pay_we = 1'b0;
		if (!s_op) begin
			// A new blob empties the prefix.
			if (eph_q == E_HEADER && hb_q == 3'd0) begin
				plen_n = '0;
				bad_n = 1'b0;
			end
			if (!bad_n) begin
				case (eph_q)
					E_HEADER: begin
						if (hb_q == HDR_LAST) begin
							ul_n = {3'b000, s_data[4:0]};
							pps_n = 1'b0;
							hb_n = 3'd0;
							adv = 1'b1;
						end else begin
							hb_n = hb_q + 3'd1;
						end
					end
					E_SIZE_HI: begin
						ub_n = {s_data, 8'h00};
						eph_n = E_SIZE_LO;
					end
					E_SIZE_LO: begin
						ub_n = {ub_q[15:8], s_data};
						if (fit_sum > 17'(PREFIX_DEPTH)) begin
							plen_n = '0;
							bad_n = 1'b1;
							eph_n = E_DONE;
						end else begin
							plan.wr = 1'b1;
							wbase_n = plen_q[AW-1:0];
							plen_n = plen_q + LW'(4);
							if (ub_n != 16'd0) begin
								eph_n = E_PAYLOAD;
							end else begin
								adv = 1'b1;
							end
						end
					end
					E_PAYLOAD: begin
						if (plen_q < LW'(PREFIX_DEPTH)) begin
							pay_we = 1'b1;
							plen_n = plen_q + LW'(1);
						end
						if (ub_q != 16'd0) begin
							ub_n = ub_q - 16'd1;
						end
						if (ub_n == 16'd0) begin
							adv = 1'b1;
						end
					end
					E_PPS_COUNT: begin
						ul_n = s_data;
						adv = 1'b1;
					end
					default: ;
				endcase
				// Move on to the next unit, the PPS count, or the end.
				if (adv) begin
					if (ul_n != 8'd0) begin
						ul_n = ul_n - 8'd1;
						eph_n = E_SIZE_HI;
					end else if (!pps_n) begin
						pps_n = 1'b1;
						eph_n = E_PPS_COUNT;
					end else begin
						eph_n = E_DONE;
					end
				end
			end
			if (s_last) begin
				if (!bad_n && eph_n != E_DONE) begin
					plen_n = '0;
					bad_n = 1'b1;
				end
				plan.st = 1'b1;
				fstat_n = bad_n ? avcc2ab_pkg::ST_BAD_EXTRA : avcc2ab_pkg::ST_OK;
				eph_n = E_HEADER;
				hb_n = 3'd0;
				ul_n = 8'd0;
				ub_n = 16'd0;
				pps_n = 1'b0;
				bad_n = 1'b0;
			end
		end else begin
			case (pph_q)
				P_LEN: begin
					if (lb_q == 2'd3) begin
						lb_n = 2'd0;
						if (nlv[31]) begin
							plan.st = 1'b1;
							fstat_n = avcc2ab_pkg::ST_NEG_LEN;
							pph_n = P_SKIP;
						end else if (nlv == 32'd0) begin
							plan.sc = 1'b1;
						end else begin
							nbl_n = nlv[30:0];
							pph_n = P_HEAD;
							if (s_last) begin
								plan.st = 1'b1;
								fstat_n = avcc2ab_pkg::ST_TRUNC;
							end
						end
						nl_n = 24'd0;
					end else begin
						lb_n = lb_q + 2'd1;
						nl_n = nlv[23:0];
						if (s_last) begin
							plan.st = 1'b1;
							fstat_n = avcc2ab_pkg::ST_TRUNC;
						end
					end
				end
				P_HEAD, P_BODY: begin
					if (pph_q == P_HEAD) begin
						plan.rep = (s_data[4:0] == avcc2ab_pkg::NAL_TYPE_IDR) &&
							(plen_q != '0);
						plan.sc = 1'b1;
					end
					plan.dat = 1'b1;
					if (nbl_q != 31'd0) begin
						nbl_n = nbl_q - 31'd1;
					end
					pph_n = (nbl_n != 31'd0) ? P_BODY : P_LEN;
					if (s_last && nbl_n != 31'd0) begin
						fstat_n = avcc2ab_pkg::ST_TRUNC;
					end
				end
				default: begin
					if (s_last) begin
						plan.st = 1'b1;
						fstat_n = avcc2ab_pkg::ST_NEG_LEN;
					end
				end
			endcase
			if (s_last) begin
				pph_n = P_LEN;
				lb_n = 2'd0;
				nl_n = 24'd0;
				nbl_n = 31'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eph_q <= E_HEADER;
			hb_q <= 3'd0;
			ul_q <= 8'd0;
			ub_q <= 16'd0;
			pps_q <= 1'b0;
			bad_q <= 1'b0;
			plen_q <= '0;
			pph_q <= P_LEN;
			lb_q <= 2'd0;
			nl_q <= 24'd0;
			nbl_q <= 31'd0;
			dat_q <= 1'b0;
			st_q <= 1'b0;
			eop_q <= 1'b0;
			fstat_q <= avcc2ab_pkg::ST_OK;
			idx_q <= '0;
			ovld_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				eph_q <= eph_n;
				hb_q <= hb_n;
				ul_q <= ul_n;
				ub_q <= ub_n;
				pps_q <= pps_n;
				bad_q <= bad_n;
				plen_q <= plen_n;
				pph_q <= pph_n;
				lb_q <= lb_n;
				nl_q <= nl_n;
				nbl_q <= nbl_n;
				dat_q <= plan.dat;
				st_q <= plan.st;
				eop_q <= s_last;
				fstat_q <= fstat_n;
				idx_q <= '0;
			end else if (cmd.emit && cmd.sel == avcc2ab_pkg::EM_PREFIX && !rep_last) begin
				idx_q <= idx_q + AW'(1);
			end
			if (cmd.emit) begin
				ovld_q <= 1'b1;
			end else if (m_ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= s_data;
			wbase_q <= wbase_n;
		end
		if (cmd.emit) begin
			obyte_q <= emit_byte;
			obv_q <= (cmd.sel != avcc2ab_pkg::EM_STAT);
			olast_q <= cmd.last_res;
			oeop_q <= cmd.last_res && eop_q;
			ostat_q <= cmd.last_res ? fstat_q : avcc2ab_pkg::ST_OK;
		end
	end

	always_comb begin
		case (cmd.sel)
			avcc2ab_pkg::EM_PREFIX: emit_byte = ram_rdata;
			avcc2ab_pkg::EM_ONE:    emit_byte = 8'h01;
			avcc2ab_pkg::EM_DATA:   emit_byte = byte_q;
			default:                emit_byte = 8'h00;
		endcase
	end

	// Write port: start codes from the controller, payload bytes on accept.
	assign ram_we    = cmd.wr_sc || (cmd.accept && pay_we);
	assign ram_waddr = cmd.wr_sc ? (wbase_q + AW'(cmd.wr_k)) : plen_q[AW-1:0];
	assign ram_wdata = cmd.wr_sc ? ((cmd.wr_k == 2'd3) ? 8'h01 : 8'h00) : s_data;

	// The read address runs one byte ahead so that replay streams one byte a cycle while the output is free.
	always_comb begin
		if (cmd.accept) begin
			ram_raddr = '0;
		end else if (cmd.emit && cmd.sel == avcc2ab_pkg::EM_PREFIX && !rep_last) begin
			ram_raddr = idx_q + AW'(1);
		end else begin
			ram_raddr = idx_q;
		end
	end

	avcc2ab_ram #(
		.WIDTH(8),
		.DEPTH(PREFIX_DEPTH)
	) u_prefix_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign stat.plan_in  = plan;
	assign stat.dat_q    = dat_q;
	assign stat.st_q     = st_q;
	assign stat.rep_last = rep_last;
	assign stat.out_free = out_free;

	assign m_valid = ovld_q;
	assign m_data  = obyte_q;
	assign m_user  = {ostat_q, oeop_q, obv_q};
	assign m_last  = olast_q;

endmodule

// ===== sv/avcc_to_annexb_nal_converter_unit.sv =====
// Top level of the length-prefixed (AVCC) to start-code (Annex B) H.264 converter.
// Depends on avcc2ab_pkg, avcc2ab_ctrl and avcc2ab_dp.
`timescale 1ns / 1ps

// The block takes one byte per input word, either an extradata byte
// (tuser = 0) or a packet byte (tuser = 1), with tlast on the final byte of an
// extradata blob or a packet. Extradata is parsed into a prefix memory that holds
// every SPS and PPS unit behind a 00 00 00 01 start code. Packet bytes carry a
// four-byte big-endian length and then the NAL; every NAL leaves the block
// behind 00 00 01, and an IDR slice is preceded by the stored prefix and one
// more zero byte. Each output word carries one byte or, with the byte-valid bit
// clear, a status only; tlast closes the words of one input word. While the
// output does not stall, a word that produces a single output word (a NAL body
// byte, a status) lets the next input word in as it emits, so bodies stream at
// one byte a cycle. A NAL header byte emits 00 00 01 and itself; an IDR header
// byte first replays the prefix, one byte a cycle when not stalled, then a zero
// byte. A zero length emits only 00 00 01. The extradata byte that closes a unit
// size holds off the input while the start code is written into the prefix
// memory through its single write port. The prefix memory needs no clearing
// after reset: only bytes below the stored prefix length are read.
module avcc_to_annexb_nal_converter_unit #(
	parameter int PREFIX_DEPTH = avcc2ab_pkg::PREFIX_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,

	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0] s_axis_tuser,  // [0] opcode
	input  logic       s_axis_tlast,  // last_byte

	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic [3:0] m_axis_tuser,  // [0] byte_valid, [1] end_of_packet, [3:2] status
	output logic       m_axis_tlast   // last_of_run
);

	// Controller and datapath talk only through these two bundles.
	avcc2ab_pkg::ctl_cmd_t   cmd;
	avcc2ab_pkg::dp_status_t stat;

	avcc2ab_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.s_valid(s_axis_tvalid),
		.s_ready(s_axis_tready),
		.stat   (stat),
		.cmd    (cmd)
	);

	avcc2ab_dp #(
		.PREFIX_DEPTH(PREFIX_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.s_data (s_axis_tdata),
		.s_op   (s_axis_tuser[0]),
		.s_last (s_axis_tlast),
		.cmd    (cmd),
		.stat   (stat),
		.m_valid(m_axis_tvalid),
		.m_ready(m_axis_tready),
		.m_data (m_axis_tdata),
		.m_user (m_axis_tuser),
		.m_last (m_axis_tlast)
	);

endmodule

// ===== sv/avcc2ab_chk.sv =====
// Port-level checks of the NAL converter's output stream, bound to the top level.
// Depends on avcc_to_annexb_nal_converter_unit.
`timescale 1ns / 1ps

module avcc2ab_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic [3:0] m_axis_tuser,
	input logic       m_axis_tlast
);

	// A stalled output word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
		$stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	// A status-only word stands alone and carries a zero byte.
	a_stat_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 8'h00))
		else $error("status-only word is not a lone zero word");

	// End of packet is only flagged on the last word of a run.
	a_eop_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
		else $error("end of packet before end of run");

	// An error status only appears on the closing word of a run.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[3:2] != 2'd0) |-> m_axis_tlast)
		else $error("error status on a word inside a run");

	// Bad extradata is reported only by the status word that closes the blob.
	a_bad_extra: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser[3:2] == 2'd3) |-> !m_axis_tuser[0] && m_axis_tuser[1])
		else $error("bad extradata status outside a closing status word");

endmodule

bind avcc_to_annexb_nal_converter_unit avcc2ab_chk u_avcc2ab_chk (.*);

// ===== tb/tb_avcc_to_annexb_nal_converter_unit.sv =====
// Self-checking bench for the length-prefixed to start-code NAL converter.
// Drives extradata blobs and packets into the converter, predicts its output words
// and checks them; depends on avcc2ab_pkg and avcc_to_annexb_nal_converter_unit.
`timescale 1ns / 1ps

module tb_avcc_to_annexb_nal_converter_unit;

	localparam int PFX_DEPTH = avcc2ab_pkg::PREFIX_DEPTH_DEF;
	localparam int RANDOM_WORDS = 130;
	// Worst case is roughly every input word an IDR header with a full prefix
	// (61 output words), each output word behind the longest receive stall.
	// The limit sits several times above that.
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int DRAIN_CYCLES = 200;

	// Opcodes carried in s_axis_tuser.
	localparam logic OP_EXTRA = 1'b0;
	localparam logic OP_PACKET = 1'b1;

	// Parse position inside an extradata blob.
	typedef enum logic [2:0] {
		PS_HEADER,
		PS_SIZE_HI,
		PS_SIZE_LO,
		PS_PAYLOAD,
		PS_PPS_COUNT,
		PS_DONE
	} ps_phase_t;

	// Parse position inside a packet.
	typedef enum logic [1:0] {
		NS_LENGTH,
		NS_HEADER,
		NS_BODY,
		NS_SKIP
	} ns_phase_t;

	typedef struct packed {
		logic       opcode;
		logic [7:0] data;
		logic       last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last_of_run;
		logic       end_of_packet;
		logic [1:0] status;
	} out_word_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;  // [7:0] data_byte
	logic [0:0] s_axis_tuser = 1'b0;   // [0] opcode
	logic       s_axis_tlast = 1'b0;   // last_byte
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;          // [7:0] out_byte
	logic [3:0] m_axis_tuser;          // [0] byte_valid, [1] end_of_packet, [3:2] status
	logic       m_axis_tlast;          // last_of_run

	avcc_to_annexb_nal_converter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Words waiting to be sent, and the output words the converter still owes.
	in_word_t  avcc_pending[$];
	out_word_t annexb_due[$];
	out_word_t run_q[$];
	int        pushed_cnt = 0;
	bit        failed = 1'b0;

	// Predictor state: the prefix memory and the two parsers.
	logic [7:0] pfx_mem [PFX_DEPTH];
	int         pfx_len = 0;
	ps_phase_t  ps_phase = PS_HEADER;
	int         hdr_seen = 0;
	int         sets_left = 0;
	int         set_bytes_left = 0;
	bit         in_pps = 1'b0;
	bit         load_bad = 1'b0;
	ns_phase_t  ns_phase = NS_LENGTH;
	int         len_seen = 0;
	logic [31:0] len_acc = '0;
	logic [31:0] nal_left = '0;

	task automatic emit(input logic [7:0] b, input logic v, input logic [1:0] st);
		out_word_t w;
		w = '0;
		w.out_byte = b;
		w.byte_valid = v;
		w.status = st;
		run_q.push_back(w);
	endtask

	task automatic keep_byte(input logic [7:0] b);
		if (pfx_len < PFX_DEPTH) begin
			pfx_mem[pfx_len] = b;
			pfx_len++;
		end
	endtask

	// Move on to the next parameter set, or from the SPS list to the PPS count.
	task automatic advance_set();
		if (sets_left > 0) begin
			sets_left--;
			ps_phase = PS_SIZE_HI;
		end else if (!in_pps) begin
			in_pps = 1'b1;
			ps_phase = PS_PPS_COUNT;
		end else begin
			ps_phase = PS_DONE;
		end
	endtask

	task automatic drop_prefix();
		pfx_len = 0;
		load_bad = 1'b1;
		ps_phase = PS_DONE;
	endtask

	// Works out the output words of one accepted input word and queues them.
	task automatic convert_word(input logic op, input logic [7:0] b, input logic last);
		int i;
		if (op == OP_EXTRA) begin
			// The first byte of a blob starts a fresh prefix.
			if (ps_phase == PS_HEADER && hdr_seen == 0) begin
				pfx_len = 0;
				load_bad = 1'b0;
			end
			if (!load_bad) begin
				case (ps_phase)
				PS_HEADER: begin
					if (hdr_seen >= 5) begin
						sets_left = b[4:0];
						in_pps = 1'b0;
						hdr_seen = 0;
						advance_set();
					end else begin
						hdr_seen++;
					end
				end
				PS_SIZE_HI: begin
					set_bytes_left = {b, 8'h00};
					ps_phase = PS_SIZE_LO;
				end
				PS_SIZE_LO: begin
					set_bytes_left = set_bytes_left | b;
					if (pfx_len + 4 + set_bytes_left > PFX_DEPTH) begin
						drop_prefix();
					end else begin
						keep_byte(8'h00);
						keep_byte(8'h00);
						keep_byte(8'h00);
						keep_byte(8'h01);
						if (set_bytes_left > 0)
							ps_phase = PS_PAYLOAD;
						else
							advance_set();
					end
				end
				PS_PAYLOAD: begin
					keep_byte(b);
					if (set_bytes_left > 0)
						set_bytes_left--;
					if (set_bytes_left == 0)
						advance_set();
				end
				PS_PPS_COUNT: begin
					sets_left = b;
					advance_set();
				end
				default: ;
				endcase
			end
			if (last) begin
				// A blob that stops before the parse is complete is as bad as an
				// oversized one.
				if (!load_bad && ps_phase != PS_DONE)
					drop_prefix();
				emit(8'h00, 1'b0,
					load_bad ? avcc2ab_pkg::ST_BAD_EXTRA : avcc2ab_pkg::ST_OK);
				ps_phase = PS_HEADER;
				hdr_seen = 0;
				sets_left = 0;
				set_bytes_left = 0;
				in_pps = 1'b0;
				load_bad = 1'b0;
			end
		end else begin
			case (ns_phase)
			NS_LENGTH: begin
				len_acc = {len_acc[23:0], b};
				if (len_seen >= 3) begin
					len_seen = 0;
					if (len_acc[31]) begin
						emit(8'h00, 1'b0, avcc2ab_pkg::ST_NEG_LEN);
						ns_phase = NS_SKIP;
					end else if (len_acc == 0) begin
						emit(8'h00, 1'b1, avcc2ab_pkg::ST_OK);
						emit(8'h00, 1'b1, avcc2ab_pkg::ST_OK);
						emit(8'h01, 1'b1, avcc2ab_pkg::ST_OK);
					end else begin
						nal_left = len_acc;
						ns_phase = NS_HEADER;
						if (last)
							emit(8'h00, 1'b0, avcc2ab_pkg::ST_TRUNC);
					end
					len_acc = '0;
				end else begin
					len_seen++;
					if (last)
						emit(8'h00, 1'b0, avcc2ab_pkg::ST_TRUNC);
				end
			end
			NS_HEADER, NS_BODY: begin
				if (ns_phase == NS_HEADER) begin
					// An IDR slice carries the parameter sets in front of it.
					if (b[4:0] == avcc2ab_pkg::NAL_TYPE_IDR && pfx_len > 0) begin
						for (i = 0; i < pfx_len; i++)
							emit(pfx_mem[i], 1'b1, avcc2ab_pkg::ST_OK);
						emit(8'h00, 1'b1, avcc2ab_pkg::ST_OK);
					end
					emit(8'h00, 1'b1, avcc2ab_pkg::ST_OK);
					emit(8'h00, 1'b1, avcc2ab_pkg::ST_OK);
					emit(8'h01, 1'b1, avcc2ab_pkg::ST_OK);
				end
				emit(b, 1'b1, avcc2ab_pkg::ST_OK);
				if (nal_left > 0)
					nal_left--;
				ns_phase = (nal_left > 0) ? NS_BODY : NS_LENGTH;
				if (last && nal_left > 0)
					run_q[run_q.size() - 1].status = avcc2ab_pkg::ST_TRUNC;
			end
			default: begin
				if (last)
					emit(8'h00, 1'b0, avcc2ab_pkg::ST_NEG_LEN);
			end
			endcase
			if (last) begin
				ns_phase = NS_LENGTH;
				len_seen = 0;
				len_acc = '0;
				nal_left = '0;
			end
		end
		if (run_q.size() > 0) begin
			run_q[run_q.size() - 1].last_of_run = 1'b1;
			if (last)
				run_q[run_q.size() - 1].end_of_packet = 1'b1;
		end
		foreach (run_q[i])
			annexb_due.push_back(run_q[i]);
		run_q.delete();
	endtask

	// Idle length: mostly none or short, now and then long. A calm stretch has none.
	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 24);
	endfunction

	task automatic push_word(input logic op, input logic [7:0] b, input logic last);
		in_word_t w;
		w.opcode = op;
		w.data = b;
		w.last = last;
		avcc_pending.push_back(w);
		pushed_cnt++;
	endtask

	// One packet: a few well-formed NAL units, sometimes followed by a broken
	// tail (truncated NAL, negative length, or a length cut short).
	task automatic gen_packet();
		logic [7:0]  seq[$];
		logic [31:0] len_field;
		logic [7:0]  v;
		int          mode;
		int          n_nal;
		int          len;
		int          r;
		int          k;
		mode = $urandom_range(0, 99);
		n_nal = $urandom_range(1, 3);
		for (int j = 0; j < n_nal; j++) begin
			r = $urandom_range(0, 19);
			len = (r == 0) ? 0 : (r == 1) ? $urandom_range(7, 24) : $urandom_range(1, 5);
			len_field = len;
			for (int s = 3; s >= 0; s--)
				seq.push_back(len_field[s * 8 +: 8]);
			if (len > 0) begin
				v = 8'($urandom);
				if ($urandom_range(0, 1) == 0)
					v[4:0] = avcc2ab_pkg::NAL_TYPE_IDR;
				seq.push_back(v);
				for (int s = 1; s < len; s++)
					seq.push_back(8'($urandom));
			end
		end
		if (mode >= 72 && mode < 84) begin
			// Length promises more bytes than the packet holds.
			k = $urandom_range(0, 3);
			len_field = $urandom;
			len_field[31] = 1'b0;
			if (len_field <= k)
				len_field = k + 1;
			for (int s = 3; s >= 0; s--)
				seq.push_back(len_field[s * 8 +: 8]);
			for (int s = 0; s < k; s++)
				seq.push_back(8'($urandom));
		end else if (mode >= 84 && mode < 93) begin
			k = $urandom_range(0, 3);
			len_field = $urandom;
			len_field[31] = 1'b1;
			for (int s = 3; s >= 0; s--)
				seq.push_back(len_field[s * 8 +: 8]);
			for (int s = 0; s < k; s++)
				seq.push_back(8'($urandom));
		end else if (mode >= 93) begin
			k = $urandom_range(1, 3);
			for (int s = 0; s < k; s++)
				seq.push_back(8'($urandom));
		end
		foreach (seq[j])
			push_word(OP_PACKET, seq[j], j == seq.size() - 1);
	endtask

	// One extradata blob: SPS list and PPS list of small units, now and then a
	// unit large enough to fill or overflow the prefix, a size out of range,
	// trailing bytes, an early end, or a packet sent in the middle of it.
	task automatic gen_blob();
		logic [7:0] seq[$];
		logic [7:0] v;
		int         n_sps;
		int         n_pps;
		int         sz;
		int         mix_at;
		bit         big;
		n_sps = $urandom_range(0, 2);
		n_pps = $urandom_range(0, 2);
		big = ($urandom_range(0, 7) == 0);
		repeat (5)
			seq.push_back(8'($urandom));
		v = 8'($urandom);
		v[4:0] = 5'(n_sps);
		seq.push_back(v);
		for (int j = 0; j < n_sps + n_pps; j++) begin
			if (j == n_sps)
				seq.push_back(8'(n_pps));
			sz = (big && j == 0) ? $urandom_range(44, 54) : $urandom_range(0, 4);
			if ($urandom_range(0, 15) == 0)
				seq.push_back(8'($urandom_range(1, 255)));
			else
				seq.push_back(8'(sz >> 8));
			seq.push_back(sz[7:0]);
			for (int s = 0; s < sz; s++)
				seq.push_back(8'($urandom));
		end
		if (n_pps == 0)
			seq.push_back(8'h00);
		if ($urandom_range(0, 7) == 0)
			repeat ($urandom_range(1, 3))
				seq.push_back(8'($urandom));
		if ($urandom_range(0, 7) == 0)
			seq = seq[0 : $urandom_range(0, seq.size() - 2)];
		mix_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, seq.size() - 1) : -1;
		foreach (seq[j]) begin
			if (j == mix_at)
				gen_packet();
			push_word(OP_EXTRA, seq[j], j == seq.size() - 1);
		end
	endtask

	// Random bytes on one opcode, closed by a last byte so the next sequence
	// starts from a clean parser state.
	task automatic gen_noise();
		logic op;
		int   n;
		op = 1'($urandom_range(0, 1));
		n = $urandom_range(1, 6);
		for (int j = 0; j < n; j++)
			push_word(op, 8'($urandom), j == n - 1);
	endtask

	task automatic wait_drained();
		while (avcc_pending.size() > 0 || s_axis_tvalid)
			@(posedge clk);
		while (annexb_due.size() > 0)
			@(posedge clk);
	endtask

	// Driver: presents the head of the pending queue, holds it until it is
	// taken, and predicts the output words of every word the converter accepts.
	int tx_idle = 0;
	bit tx_calm = 1'b0;
	bit word_held;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= 8'h00;
			s_axis_tuser <= OP_EXTRA;
			s_axis_tlast <= 1'b0;
		end else begin
			word_held = s_axis_tvalid && !s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				convert_word(s_axis_tuser[0], s_axis_tdata, s_axis_tlast);
				void'(avcc_pending.pop_front());
				tx_idle = pick_gap(tx_calm);
				if ($urandom_range(0, 39) == 0)
					tx_calm = !tx_calm;
			end
			if (!word_held) begin
				if (tx_idle > 0) begin
					tx_idle--;
					s_axis_tvalid <= 1'b0;
				end else if (avcc_pending.size() > 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= avcc_pending[0].data;
					s_axis_tuser <= avcc_pending[0].opcode;
					s_axis_tlast <= avcc_pending[0].last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks every accepted output word against the oldest one owed,
	// and stalls the output side at random.
	int        rx_stall = 0;
	bit        rx_calm = 1'b0;
	out_word_t due;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (annexb_due.size() == 0) begin
					$error("output word with none owed: tdata %0h tuser %0h tlast %0b",
						m_axis_tdata, m_axis_tuser, m_axis_tlast);
					failed = 1'b1;
				end else begin
					due = annexb_due.pop_front();
					if (m_axis_tdata !== due.out_byte) begin
						$error("out_byte: expected %0h, got %0h", due.out_byte, m_axis_tdata);
						failed = 1'b1;
					end
					if (m_axis_tuser[0] !== due.byte_valid) begin
						$error("byte_valid: expected %0b, got %0b",
							due.byte_valid, m_axis_tuser[0]);
						failed = 1'b1;
					end
					if (m_axis_tlast !== due.last_of_run) begin
						$error("last_of_run: expected %0b, got %0b",
							due.last_of_run, m_axis_tlast);
						failed = 1'b1;
					end
					if (m_axis_tuser[1] !== due.end_of_packet) begin
						$error("end_of_packet: expected %0b, got %0b",
							due.end_of_packet, m_axis_tuser[1]);
						failed = 1'b1;
					end
					if (m_axis_tuser[3:2] !== due.status) begin
						$error("status: expected %0d, got %0d", due.status, m_axis_tuser[3:2]);
						failed = 1'b1;
					end
				end
			end
			if (rx_stall > 0) begin
				rx_stall--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if (!rx_calm && $urandom_range(0, 5) == 0)
					rx_stall = pick_gap(1'b0);
				if ($urandom_range(0, 199) == 0)
					rx_calm = !rx_calm;
			end
		end
	end

	// Guard against a hang anywhere in the run.
	int cycle_cnt = 0;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [7:0] boot_blob [10];
		logic [7:0] idr_pkt [6];
		logic [7:0] odd_pkt [9];
		int         start_cnt;
		int         r;

		// Directed part. A minimal blob with one one-byte SPS and an empty PPS
		// list, so the prefix becomes 00 00 00 01 67.
		boot_blob = '{8'h01, 8'h64, 8'h00, 8'h1f, 8'hff, 8'he1, 8'h00, 8'h01, 8'h67, 8'h00};
		foreach (boot_blob[i])
			push_word(OP_EXTRA, boot_blob[i], i == 9);
		// An IDR slice of two bytes, which pulls the stored prefix in front of it.
		idr_pkt = '{8'h00, 8'h00, 8'h00, 8'h02, 8'h65, 8'h88};
		foreach (idr_pkt[i])
			push_word(OP_PACKET, idr_pkt[i], i == 5);
		// A zero length, then a negative length whose packet ends one byte later.
		odd_pkt = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'hff};
		foreach (odd_pkt[i])
			push_word(OP_PACKET, odd_pkt[i], i == 8);

		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The sender holds off here until the converter has delivered everything.
		wait_drained();

		// Random part, in two halves with a full drain between them. Packets
		// dominate, since they are where most of the behavior lies.
		start_cnt = pushed_cnt;
		for (int half = 1; half <= 2; half++) begin
			while (pushed_cnt - start_cnt < RANDOM_WORDS * half / 2) begin
				r = $urandom_range(0, 99);
				if (r < 20)
					gen_blob();
				else if (r < 85)
					gen_packet();
				else
					gen_noise();
			end
			if (half == 1)
				wait_drained();
		end

		wait_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (annexb_due.size() > 0) begin
			$error("%0d output words never arrived", annexb_due.size());
			failed = 1'b1;
		end
		if (!failed)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
